>>> design/pals_pkg.sv
// ----------------------------------------------------------------------------
// pals_pkg
// Constants, types and tables shared by the polyline arc length sampler.
// ----------------------------------------------------------------------------
package pals_pkg;

	localparam int MAX_SEGMENTS  = 1024;
	localparam int INDEX_DEPTH   = 1024;
	localparam int BUCKET_LENGTH = 100;

	localparam int SEG_IW = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int BKT_IW = $clog2(INDEX_DEPTH);
	localparam int BCNT_W = $clog2(INDEX_DEPTH + 1);

	// one bucket spans BUCKET_LENGTH whole units of Q24.8 length
	localparam longint BKT_UNIT = longint'(BUCKET_LENGTH) * 256;
	localparam int     THR_W    = $clog2(longint'(INDEX_DEPTH) * BKT_UNIT + 1);
	localparam int     CMP_W    = (THR_W > 32) ? THR_W : 32;

	// offset / BKT_UNIT as (offset >> 8) * RECIP >> RECIP_SH
	localparam int     V_W      = 23;
	localparam int     RECIP_SH = 32;
	localparam longint RECIP    = ((64'd1 << RECIP_SH) + BUCKET_LENGTH - 1) / BUCKET_LENGTH;
	localparam int     RECIP_W  = $clog2(RECIP + 1);
	localparam int     PROD_W   = V_W + RECIP_W;
	localparam int     QW       = PROD_W - RECIP_SH;
	localparam int     CMPQ     = (QW > BCNT_W) ? QW : BCNT_W;

	localparam int CORDIC_STEPS = 14;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 44;
	localparam int ZW           = 17;
	localparam logic [23:0] GAIN_Q24 = 24'd10188014;
	localparam logic signed [CW-1:0] GAIN_Q28 = 44'sd163008219;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_POINT = 3'd1;
	localparam logic [2:0] OP_ANGLE = 3'd2;
	localparam logic [2:0] OP_VAR   = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic        [31:0] offset;
		logic        [31:0] length;
		logic signed [15:0] angle;
	} seg_word_t;

	typedef struct packed {
		logic              en;
		logic [SEG_IW-1:0] addr;
		seg_word_t         data;
	} seg_wr_t;

	typedef struct packed {
		logic              en;
		logic [BKT_IW-1:0] addr;
		logic [SEG_IW-1:0] data;
	} bkt_wr_t;

	typedef struct packed {
		logic               start;
		logic               vect;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [15:0] angle;
	} cordic_cmd_t;

	typedef struct packed {
		logic                 done;
		logic                 neg;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_res_t;

	// atan(2^-k) in binary angle units, 32768 = pi
	function automatic logic [13:0] atan_unit(input logic [STEP_W-1:0] k);
		logic [13:0] a;
		case (k)
			4'd0:    a = 14'd8192;
			4'd1:    a = 14'd4836;
			4'd2:    a = 14'd2555;
			4'd3:    a = 14'd1297;
			4'd4:    a = 14'd651;
			4'd5:    a = 14'd326;
			4'd6:    a = 14'd163;
			4'd7:    a = 14'd81;
			4'd8:    a = 14'd41;
			4'd9:    a = 14'd20;
			4'd10:   a = 14'd10;
			4'd11:   a = 14'd5;
			4'd12:   a = 14'd3;
			4'd13:   a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

endpackage

>>> design/pals_if.sv
// ----------------------------------------------------------------------------
// pals channel interfaces
// Request, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pals_req_if;
	import pals_pkg::*;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] query_offset;
	logic signed [31:0] query_end_offset;
	logic [15:0]        max_angle_change;
	modport source (output valid, opcode, point_x, point_y, query_offset,
		query_end_offset, max_angle_change, input ready);
	modport sink (input valid, opcode, point_x, point_y, query_offset,
		query_end_offset, max_angle_change, output ready);
endinterface

interface pals_rsp_if;
	import pals_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [15:0] out_angle;
	logic               variance_ok;
	logic [1:0]         status;
	logic [CNT_W-1:0]   segment_total;
	logic [31:0]        path_length;
	modport source (output valid, out_x, out_y, out_angle, variance_ok, status,
		segment_total, path_length, input ready);
	modport sink (input valid, out_x, out_y, out_angle, variance_ok, status,
		segment_total, path_length, output ready);
endinterface

interface pals_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> design/pals_cordic.sv
// ----------------------------------------------------------------------------
// pals_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module pals_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pals_pkg::cordic_cmd_t cmd,
	output pals_pkg::cordic_res_t res
);
	import pals_pkg::*;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [STEP_W-1:0]    k_q;
	logic                 busy_q, vect_q, neg_q, done_q;

	logic signed [CW-1:0] x0, y0, xs, ys, dx64;
	logic signed [ZW-1:0] z0, za, zin;
	logic                 neg0, up;

	always_comb begin
		dx64 = CW'(cmd.dx) <<< 6;
		x0   = GAIN_Q28;
		y0   = '0;
		z0   = '0;
		neg0 = 1'b0;
		zin  = ZW'(cmd.angle);
		if (cmd.vect) begin
			// left half plane: turn by pi first
			if (dx64 < 0) begin
				x0 = -dx64;
				y0 = -(CW'(cmd.dy) <<< 6);
				z0 = 17'sd32768;
			end else begin
				x0 = dx64;
				y0 = CW'(cmd.dy) <<< 6;
			end
		end else begin
			z0 = zin;
			if (zin > 17'sd16384) begin
				z0   = zin - 17'sd32768;
				neg0 = 1'b1;
			end else if (zin < -17'sd16384) begin
				z0   = zin + 17'sd32768;
				neg0 = 1'b1;
			end
		end
	end

	assign xs = x_q >>> k_q;
	assign ys = y_q >>> k_q;
	assign za = ZW'($signed({1'b0, atan_unit(k_q)}));
	assign up = vect_q ? (y_q > 0) : (z_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				if (k_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			vect_q <= cmd.vect;
			neg_q  <= neg0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + za;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - za;
			end
		end
	end

	assign res.done = done_q;
	assign res.neg  = neg_q;
	assign res.x    = x_q;
	assign res.y    = y_q;
	assign res.z    = z_q;

endmodule

>>> design/pals_store.sv
// ----------------------------------------------------------------------------
// pals_store
// Segment table and bucket index, synchronous RAMs with registered reads.
// ----------------------------------------------------------------------------
module pals_store (
	input  logic                          clk,
	input  pals_pkg::seg_wr_t             seg_wr,
	input  logic [pals_pkg::SEG_IW-1:0]   seg_rd_addr,
	output pals_pkg::seg_word_t           seg_rd_q,
	input  pals_pkg::bkt_wr_t             bkt_wr,
	input  logic [pals_pkg::BKT_IW-1:0]   bkt_rd_addr,
	output logic [pals_pkg::SEG_IW-1:0]   bkt_rd_q
);
	import pals_pkg::*;

	seg_word_t         seg_mem [MAX_SEGMENTS];
	logic [SEG_IW-1:0] bkt_mem [INDEX_DEPTH];

	always_ff @(posedge clk) begin
		if (seg_wr.en)
			seg_mem[seg_wr.addr] <= seg_wr.data;
		seg_rd_q <= seg_mem[seg_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (bkt_wr.en)
			bkt_mem[bkt_wr.addr] <= bkt_wr.data;
		bkt_rd_q <= bkt_mem[bkt_rd_addr];
	end

endmodule

>>> design/polyline_arc_length_sampler_unit.sv
// ----------------------------------------------------------------------------
// polyline_arc_length_sampler_unit
// Simplified polyline store with offset lookups and an angle spread test.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; its result sits in an output register
// so the next transaction can be taken while it waits. Adding a point waits on
// the shared CORDIC, runs the length multiply as a low and a high half, then
// fills the bucket entries that the new length reaches; a dropped point ends
// after the length check and the first point of a path only opens a segment.
// A point or angle query reads the bucket start unless the offset falls in
// bucket 0 and scans the segments from there; a point query then runs the
// rotation and multiply. The spread test scans the segment RAM from entry 0.
// No clearing pass is run.
module polyline_arc_length_sampler_unit (
	input  logic     clk,
	input  logic     arst_n,
	pals_req_if.sink   req,
	pals_rsp_if.source rsp,
	pals_cfg_if.sink   cfg
);
	import pals_pkg::*;

	localparam int ACC_W = 67;
	localparam logic signed [ACC_W-1:0] ROUND28 = 67'sd134217728;
	localparam logic signed [ACC_W-1:0] SMAX    = 67'sd2147483647;
	localparam logic signed [ACC_W-1:0] SMIN    = -67'sd2147483648;

	typedef enum logic [21:0] {
		S_IDLE     = 22'h000001,
		S_ADD_RD   = 22'h000002,
		S_VEC      = 22'h000004,
		S_VEC_WAIT = 22'h000008,
		S_LEN_LO   = 22'h000010,
		S_LEN_HI   = 22'h000020,
		S_LEN_CK   = 22'h000040,
		S_FILL     = 22'h000080,
		S_OPEN     = 22'h000100,
		S_DIV      = 22'h000200,
		S_BSEL     = 22'h000400,
		S_BKT_RD   = 22'h000800,
		S_BKT_USE  = 22'h001000,
		S_SCAN_RD  = 22'h002000,
		S_SCAN_CK  = 22'h004000,
		S_ROT_WAIT = 22'h008000,
		S_PT_LO    = 22'h010000,
		S_PT_HI    = 22'h020000,
		S_PT_FIN   = 22'h040000,
		S_VAR_RD   = 22'h080000,
		S_VAR_CK   = 22'h100000,
		S_DONE     = 22'h200000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > SMAX)
			r = 32'sh7FFFFFFF;
		else if (v < SMIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	state_t state_q;

	logic [31:0]        min_q;
	logic [CNT_W-1:0]   count_q, idx_q;
	logic [BCNT_W-1:0]  bcount_q;
	logic [THR_W-1:0]   thr_q;
	logic [31:0]        total_q;
	logic [BKT_IW-1:0]  b_q;

	logic [2:0]         op_q;
	logic signed [31:0] px_q, py_q, qoff_q, qend_q;
	logic [15:0]        lim_q;

	logic [PROD_W-1:0]        prod_q;
	logic [65:0]              len_acc_q;
	logic signed [31:0]       c_q, s_q;
	logic signed [33:0]       mul_q;
	logic signed [ACC_W-1:0]  accc_q, accs_q;
	logic                     have_q;
	logic signed [15:0]       first_q;

	logic signed [31:0] rx_q, ry_q;
	logic signed [15:0] rang_q;
	logic               rok_q;
	logic [1:0]         rstat_q;

	logic               ovalid_q;
	logic signed [31:0] ox_q, oy_q;
	logic signed [15:0] oang_q;
	logic               ook_q;
	logic [1:0]         ostat_q;
	logic [CNT_W-1:0]   ocnt_q;
	logic [31:0]        olen_q;

	seg_word_t          rd;
	logic [SEG_IW-1:0]  bkt_rd;
	seg_wr_t            seg_wr;
	bkt_wr_t            bkt_wr;
	cordic_cmd_t        cmd;
	cordic_res_t        cres;

	pals_store u_store (
		.clk         (clk),
		.seg_wr      (seg_wr),
		.seg_rd_addr (idx_q[SEG_IW-1:0]),
		.seg_rd_q    (rd),
		.bkt_wr      (bkt_wr),
		.bkt_rd_addr (b_q),
		.bkt_rd_q    (bkt_rd)
	);

	pals_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (cres)
	);

	// ---- datapath terms ----
	logic [CNT_W-1:0]   last_idx;
	logic [65:0]        len_rnd;
	logic [35:0]        len_m;
	logic [31:0]        seg_dist;
	logic [32:0]        sum33;
	logic [31:0]        tot_new;
	logic               fill_go;
	logic [V_W-1:0]     div_v;
	logic [QW-1:0]      div_q;
	logic [BKT_IW-1:0]  b_sel;
	logic signed [33:0] qoff34, qend34, seg_end34, seg_off34;
	logic               hit, found, at_last, off_gt_end, overlap, viol;
	logic signed [16:0] adiff;
	logic [16:0]        aabs, adist;
	logic signed [31:0] c_new, s_new;
	logic signed [17:0] mlo;
	logic signed [16:0] mhi;
	logic signed [49:0] plo_c, plo_s;
	logic signed [48:0] phi_c, phi_s;
	logic signed [ACC_W-1:0] tc, ts;
	logic               out_load;

	assign last_idx = count_q - 1'b1;
	assign len_rnd  = len_acc_q + (66'd1 << 29);
	assign len_m    = len_rnd[65:30];
	assign seg_dist = (|len_m[35:32]) ? 32'hFFFFFFFF : len_m[31:0];
	assign sum33    = {1'b0, total_q} + {1'b0, seg_dist};
	assign tot_new  = sum33[32] ? 32'hFFFFFFFF : sum33[31:0];
	assign fill_go  = (BCNT_W'(INDEX_DEPTH) > bcount_q) && (CMP_W'(thr_q) < CMP_W'(total_q));

	assign div_v = qoff_q[31] ? '0 : qoff_q[30:8];
	assign div_q = prod_q[PROD_W-1:RECIP_SH];
	assign b_sel = (CMPQ'(div_q) >= CMPQ'(bcount_q)) ? BKT_IW'(bcount_q - 1'b1)
	                                                  : BKT_IW'(div_q);

	assign qoff34    = 34'(qoff_q);
	assign qend34    = 34'(qend_q);
	assign seg_off34 = $signed({2'b00, rd.offset});
	assign seg_end34 = $signed({1'b0, {1'b0, rd.offset} + {1'b0, rd.length}});
	assign hit       = qoff34 < seg_end34;
	assign at_last   = (idx_q == last_idx);
	assign found     = hit || at_last;
	assign off_gt_end = seg_off34 > qend34;
	assign overlap    = seg_end34 > qoff34;

	// angle difference folded into [0, pi]
	assign adiff = {first_q[15], first_q} - {rd.angle[15], rd.angle};
	assign aabs  = adiff[16] ? 17'(-adiff) : 17'(adiff);
	assign adist = (aabs > 17'd32768) ? 17'd65536 - aabs : aabs;
	assign viol  = adist > {1'b0, lim_q};

	assign c_new = cres.neg ? -cres.x[31:0] : cres.x[31:0];
	assign s_new = cres.neg ? -cres.y[31:0] : cres.y[31:0];
	assign mlo   = $signed({1'b0, mul_q[16:0]});
	assign mhi   = mul_q[33:17];
	assign plo_c = c_q * mlo;
	assign plo_s = s_q * mlo;
	assign phi_c = c_q * mhi;
	assign phi_s = s_q * mhi;
	assign tc    = (accc_q + ROUND28) >>> 28;
	assign ts    = (accs_q + ROUND28) >>> 28;

	always_comb begin
		cmd.start = 1'b0;
		cmd.vect  = 1'b0;
		cmd.dx    = 33'(px_q) - 33'(rd.sx);
		cmd.dy    = 33'(rd.sy) - 33'(py_q);
		cmd.angle = rd.angle;
		if (state_q == S_VEC) begin
			cmd.start = 1'b1;
			cmd.vect  = 1'b1;
		end else if (state_q == S_SCAN_CK && found && op_q == OP_POINT) begin
			cmd.start = 1'b1;
		end
	end

	always_comb begin
		seg_wr.en   = 1'b0;
		seg_wr.addr = last_idx[SEG_IW-1:0];
		seg_wr.data = '{sx: rd.sx, sy: rd.sy, offset: rd.offset, length: seg_dist,
			angle: cres.z[15:0]};
		if (state_q == S_LEN_CK)
			seg_wr.en = (seg_dist > min_q) && (count_q < CNT_W'(MAX_SEGMENTS));
		else if (state_q == S_OPEN) begin
			seg_wr.en   = 1'b1;
			seg_wr.addr = count_q[SEG_IW-1:0];
			seg_wr.data = '{sx: px_q, sy: py_q, offset: total_q, length: '0, angle: '0};
		end
	end

	assign bkt_wr.en   = (state_q == S_FILL) && fill_go;
	assign bkt_wr.addr = bcount_q[BKT_IW-1:0];
	assign bkt_wr.data = last_idx[SEG_IW-1:0];

	assign out_load  = (state_q == S_DONE) && (!ovalid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			min_q    <= '0;
			count_q  <= '0;
			bcount_q <= BCNT_W'(1);
			thr_q    <= THR_W'(BKT_UNIT);
			total_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg.valid)
				min_q <= cfg.data;
			if (out_load)
				ovalid_q <= 1'b1;
			else if (rsp.ready)
				ovalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						unique case (req.opcode)
							OP_ADD:
								state_q <= (count_q == '0) ? S_OPEN : S_ADD_RD;
							OP_POINT, OP_ANGLE:
								state_q <= (count_q == '0) ? S_DONE : S_DIV;
							OP_VAR:
								state_q <= (count_q == '0) ? S_DONE : S_VAR_RD;
							OP_CLEAR: begin
								count_q  <= '0;
								bcount_q <= BCNT_W'(1);
								thr_q    <= THR_W'(BKT_UNIT);
								total_q  <= '0;
								state_q  <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ADD_RD:   state_q <= S_VEC;
				S_VEC:      state_q <= S_VEC_WAIT;
				S_VEC_WAIT: if (cres.done) state_q <= S_LEN_LO;
				S_LEN_LO:   state_q <= S_LEN_HI;
				S_LEN_HI:   state_q <= S_LEN_CK;
				S_LEN_CK: begin
					if (seg_dist <= min_q)
						state_q <= S_DONE;
					else if (count_q >= CNT_W'(MAX_SEGMENTS))
						state_q <= S_DONE;
					else begin
						total_q <= tot_new;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (fill_go) begin
						bcount_q <= bcount_q + 1'b1;
						thr_q    <= thr_q + THR_W'(BKT_UNIT);
					end else
						state_q <= S_OPEN;
				end
				S_OPEN: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DIV:  state_q <= S_BSEL;
				S_BSEL: state_q <= (b_sel == '0) ? S_SCAN_RD : S_BKT_RD;
				S_BKT_RD:  state_q <= S_BKT_USE;
				S_BKT_USE: state_q <= S_SCAN_RD;
				S_SCAN_RD: state_q <= S_SCAN_CK;
				S_SCAN_CK: begin
					if (!found)
						state_q <= S_SCAN_RD;
					else if (op_q == OP_POINT)
						state_q <= S_ROT_WAIT;
					else
						state_q <= S_DONE;
				end
				S_ROT_WAIT: if (cres.done) state_q <= S_PT_LO;
				S_PT_LO:  state_q <= S_PT_HI;
				S_PT_HI:  state_q <= S_PT_FIN;
				S_PT_FIN: state_q <= S_DONE;
				S_VAR_RD: state_q <= S_VAR_CK;
				S_VAR_CK: begin
					if (off_gt_end || (overlap && have_q && viol) || at_last)
						state_q <= S_DONE;
					else
						state_q <= S_VAR_RD;
				end
				S_DONE: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- working registers ----
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q    <= req.opcode;
				px_q    <= req.point_x;
				py_q    <= req.point_y;
				qoff_q  <= req.query_offset;
				qend_q  <= req.query_end_offset;
				lim_q   <= req.max_angle_change;
				idx_q   <= (req.opcode == OP_VAR) ? CNT_W'(0) : last_idx;
				have_q  <= 1'b0;
				rx_q    <= '0;
				ry_q    <= '0;
				rang_q  <= '0;
				// empty path: queries report it, the spread test also passes
				rok_q   <= (count_q == '0) && (req.opcode == OP_VAR);
				rstat_q <= ((count_q == '0) && (req.opcode == OP_POINT ||
					req.opcode == OP_ANGLE || req.opcode == OP_VAR)) ? ST_EMPTY : ST_OK;
			end
			S_LEN_LO: len_acc_q <= 66'(cres.x[20:0] * GAIN_Q24);
			S_LEN_HI: len_acc_q <= len_acc_q + (66'(cres.x[41:21] * GAIN_Q24) << 21);
			S_LEN_CK: begin
				if (seg_dist > min_q && count_q >= CNT_W'(MAX_SEGMENTS))
					rstat_q <= ST_FULL;
			end
			S_DIV: prod_q <= PROD_W'(div_v) * PROD_W'(RECIP);
			S_BSEL: begin
				b_q   <= b_sel;
				idx_q <= '0;
			end
			S_BKT_USE: idx_q <= CNT_W'(bkt_rd);
			S_SCAN_CK: begin
				if (!found)
					idx_q <= idx_q + 1'b1;
				else if (op_q == OP_ANGLE)
					rang_q <= rd.angle;
				mul_q <= qoff34 - seg_off34;
			end
			S_ROT_WAIT: begin
				c_q <= c_new;
				s_q <= s_new;
			end
			S_PT_LO: begin
				accc_q <= ACC_W'(plo_c);
				accs_q <= ACC_W'(plo_s);
			end
			S_PT_HI: begin
				accc_q <= accc_q + (ACC_W'(phi_c) <<< 17);
				accs_q <= accs_q + (ACC_W'(phi_s) <<< 17);
			end
			S_PT_FIN: begin
				rx_q <= sat32(ACC_W'(rd.sx) + tc);
				ry_q <= sat32(ACC_W'(rd.sy) - ts);
			end
			S_VAR_CK: begin
				if (off_gt_end)
					rok_q <= 1'b1;
				else if (overlap && have_q && viol)
					rok_q <= 1'b0;
				else begin
					if (overlap && !have_q) begin
						have_q  <= 1'b1;
						first_q <= rd.angle;
					end
					if (at_last)
						rok_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			ox_q    <= rx_q;
			oy_q    <= ry_q;
			oang_q  <= rang_q;
			ook_q   <= rok_q;
			ostat_q <= rstat_q;
			ocnt_q  <= count_q;
			olen_q  <= total_q;
		end
	end

	assign rsp.valid         = ovalid_q;
	assign rsp.out_x         = ox_q;
	assign rsp.out_y         = oy_q;
	assign rsp.out_angle     = oang_q;
	assign rsp.variance_ok   = ook_q;
	assign rsp.status        = ostat_q;
	assign rsp.segment_total = ocnt_q;
	assign rsp.path_length   = olen_q;

endmodule

>>> bench/tb_polyline_arc_length_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_arc_length_sampler_unit
// Self-checking bench for the polyline arc length sampler. A directed table
// covers the empty path, dropped points, extreme coordinates and clearing;
// random phases then build paths under several minimum lengths, fill the
// segment table and index, and query them. Results are checked against an
// in-bench path model or fixed row values, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_polyline_arc_length_sampler_unit;
	import pals_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam longint     UNIT_Q8     = longint'(BUCKET_LENGTH) * 256;
	localparam longint unsigned LEN_GAIN = 64'd10188014;
	localparam longint     ROT_GAIN    = 64'sd163008219;
	localparam int         ATAN_TAB [14] = '{8192, 4836, 2555, 1297, 651, 326, 163,
		81, 41, 20, 10, 5, 3, 1};
	localparam int         CYCLE_LIMIT = 20000000;

	typedef struct {
		logic [2:0]  op;
		int          x;
		int          y;
		int          qo;
		int          qe;
		logic [15:0] mac;
	} req_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] ang;
		logic               ok;
		logic [1:0]         st;
		logic [CNT_W-1:0]   cnt;
		logic [31:0]        len;
	} rsp_t;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} row_t;

	logic clk;
	logic arst_n;

	pals_req_if req_if ();
	pals_rsp_if rsp_if ();
	pals_cfg_if cfg_if ();

	polyline_arc_length_sampler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// path model state
	int          seg_x    [MAX_SEGMENTS];
	int          seg_y    [MAX_SEGMENTS];
	bit [31:0]   seg_off  [MAX_SEGMENTS];
	bit [31:0]   seg_len  [MAX_SEGMENTS];
	int          seg_ang  [MAX_SEGMENTS];
	int          bkt_first[INDEX_DEPTH];
	int          n_seg;
	int          n_bkt;
	bit [31:0]   path_len;
	bit [31:0]   min_len;

	rsp_t        pending_rsp[$];
	row_t        directed_rows[$];
	int          err_cnt;
	int          cycle_cnt;
	bit          hold;
	bit          no_idle;
	bit          req_up;
	int          next_gap;
	int          rx_stall;
	int          walk_x;
	int          walk_y;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic void clear_path();
		n_seg    = 0;
		n_bkt    = 1;
		path_len = '0;
		bkt_first[0] = 0;
	endfunction

	function automatic void measure(input longint dx, input longint dy,
			output bit [31:0] len, output int ang);
		longint x, y, xs, ys;
		int z, w;
		longint unsigned m;
		x = dx * 64;
		y = dy * 64;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32768;
		end
		for (int k = 0; k < 14; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TAB[k];
			end else begin
				x -= ys; y += xs; z -= ATAN_TAB[k];
			end
		end
		m = (longint'(x) * LEN_GAIN + (64'd1 << 29)) >> 30;
		len = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
		w = z & 32'hFFFF;
		ang = (w >= 32768) ? w - 65536 : w;
	endfunction

	function automatic void sincos(input int a, output longint c, output longint s);
		longint x, y, xs, ys;
		int z;
		bit neg;
		x = ROT_GAIN;
		y = 0;
		z = a;
		neg = 1'b0;
		if (z > 16384) begin
			z -= 32768; neg = 1'b1;
		end else if (z < -16384) begin
			z += 32768; neg = 1'b1;
		end
		for (int k = 0; k < 14; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_TAB[k];
			end else begin
				x += ys; y -= xs; z += ATAN_TAB[k];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic int locate(input longint off);
		longint b;
		b = (off < 0) ? 0 : off / UNIT_Q8;
		if (b >= n_bkt)
			b = n_bkt - 1;
		for (int i = bkt_first[b]; i < n_seg; i++)
			if (off < longint'(seg_off[i]) + longint'(seg_len[i]))
				return i;
		return n_seg - 1;
	endfunction

	function automatic void open_seg(input int x, input int y);
		seg_x[n_seg]   = x;
		seg_y[n_seg]   = y;
		seg_off[n_seg] = path_len;
		seg_len[n_seg] = '0;
		seg_ang[n_seg] = 0;
		n_seg++;
	endfunction

	function automatic logic [1:0] append_point(input int x, input int y);
		int last, a;
		bit [31:0] d;
		longint sum;
		if (n_seg == 0) begin
			open_seg(x, y);
			return ST_OK;
		end
		last = n_seg - 1;
		measure(longint'(x) - longint'(seg_x[last]), longint'(seg_y[last]) - longint'(y), d, a);
		if (d <= min_len)
			return ST_OK;
		if (n_seg >= MAX_SEGMENTS)
			return ST_FULL;
		sum = longint'(path_len) + longint'(d);
		path_len = (sum > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		seg_len[last] = d;
		seg_ang[last] = a;
		while (n_bkt < INDEX_DEPTH && longint'(n_bkt) * UNIT_Q8 < longint'(path_len)) begin
			bkt_first[n_bkt] = last;
			n_bkt++;
		end
		open_seg(x, y);
		return ST_OK;
	endfunction

	function automatic bit spread_ok(input longint st, input longint en, input int lim);
		int first, d;
		bit have;
		first = 0;
		have  = 1'b0;
		for (int i = 0; i < n_seg; i++) begin
			if (longint'(seg_off[i]) > en)
				return 1'b1;
			if (longint'(seg_off[i]) + longint'(seg_len[i]) > st) begin
				if (!have) begin
					first = seg_ang[i];
					have  = 1'b1;
				end else begin
					d = first - seg_ang[i];
					if (d < 0) d = -d;
					if (d > 32768) d = 65536 - d;
					if (d > lim)
						return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic rsp_t path_response(input req_t r);
		rsp_t res;
		int i;
		longint c, s, mul;
		res = '0;
		case (r.op)
			OP_ADD: begin
				res.st = append_point(r.x, r.y);
			end
			OP_POINT, OP_ANGLE: begin
				if (n_seg == 0) begin
					res.st = ST_EMPTY;
				end else begin
					i = locate(longint'(r.qo));
					if (r.op == OP_ANGLE) begin
						res.ang = seg_ang[i];
					end else begin
						sincos(seg_ang[i], c, s);
						mul = longint'(r.qo) - longint'(seg_off[i]);
						res.x = sat32(longint'(seg_x[i]) + ((c * mul + (64'sd1 << 27)) >>> 28));
						res.y = sat32(longint'(seg_y[i]) - ((s * mul + (64'sd1 << 27)) >>> 28));
					end
				end
			end
			OP_VAR: begin
				if (n_seg == 0) begin
					res.st = ST_EMPTY;
					res.ok = 1'b1;
				end else begin
					res.ok = spread_ok(longint'(r.qo), longint'(r.qe), int'(r.mac));
				end
			end
			OP_CLEAR: begin
				clear_path();
			end
			default: ;
		endcase
		res.cnt = n_seg;
		res.len = path_len;
		return res;
	endfunction

	function automatic rsp_t fixed_rsp(input bit ok, input logic [1:0] st, input int cnt);
		rsp_t e;
		e = '0;
		e.ok  = ok;
		e.st  = st;
		e.cnt = cnt;
		return e;
	endfunction

	task automatic add_row(input logic [2:0] op, input int x, input int y, input int qo,
			input int qe, input logic [15:0] mac, input bit typed, input rsp_t e);
		row_t rw;
		rw.r = '{op, x, y, qo, qe, mac};
		rw.typed = typed;
		rw.e = e;
		directed_rows.insert(directed_rows.size(), rw);
	endtask

	task automatic send_item(input req_t r, input bit typed, input rsp_t e);
		rsp_t p;
		if (!req_up)
			repeat (next_gap) @(posedge clk);
		req_if.valid            <= 1'b1;
		req_if.opcode           <= r.op;
		req_if.point_x          <= r.x;
		req_if.point_y          <= r.y;
		req_if.query_offset     <= r.qo;
		req_if.query_end_offset <= r.qe;
		req_if.max_angle_change <= r.mac;
		req_up = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		p = path_response(r);
		pending_rsp.insert(pending_rsp.size(), typed ? e : p);
		next_gap = draw_gap();
		if (next_gap > 0) begin
			req_if.valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	task automatic drain();
		if (req_up) begin
			req_if.valid <= 1'b0;
			req_up = 1'b0;
		end
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [31:0] v);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		min_len = v;
		@(posedge clk);
	endtask

	function automatic int pick_coord(input int base, input int step);
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return int'(longint'(base) + longint'($urandom_range(0, 2 * step)) - step);
		if (r < 95)
			return int'($urandom);
		case ($urandom_range(0, 2))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			default: return 0;
		endcase
	endfunction

	// mix: 0 small paths, 1 table filling
	function automatic req_t random_item(input int mix, input int step);
		req_t r;
		int w;
		longint span;
		r.x  = int'($urandom);
		r.y  = int'($urandom);
		r.qo = int'($urandom);
		r.qe = int'($urandom);
		r.mac = $urandom_range(0, 32768);
		w = $urandom_range(0, 99);
		if (mix == 0)
			r.op = (w < 50) ? OP_ADD : (w < 65) ? OP_POINT : (w < 77) ? OP_ANGLE :
				(w < 89) ? OP_VAR : (w < 95) ? OP_CLEAR : 3'($urandom_range(5, 7));
		else
			r.op = (w < 95) ? OP_ADD : (w < 97) ? OP_POINT : (w < 99) ? OP_ANGLE : OP_VAR;
		if (r.op == OP_ADD) begin
			walk_x = pick_coord(walk_x, step);
			walk_y = pick_coord(walk_y, step);
			r.x = walk_x;
			r.y = walk_y;
		end
		if ($urandom_range(0, 9) < 8) begin
			span = longint'(path_len) + 2 * UNIT_Q8;
			if (span > 64'sh7FFF_0000)
				span = 64'sh7FFF_0000;
			r.qo = int'(longint'($urandom_range(0, 32'(span))) - 4000);
			r.qe = int'(longint'(r.qo) + longint'($urandom_range(0, 300000)) - 20000);
		end
		return r;
	endfunction

	// result side: per-transaction stall, plus the long hold-off
	always @(posedge clk) begin
		rsp_t act, e;
		if (rsp_if.valid && rsp_if.ready) begin
			act = '{rsp_if.out_x, rsp_if.out_y, rsp_if.out_angle, rsp_if.variance_ok,
				rsp_if.status, rsp_if.segment_total, rsp_if.path_length};
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result transaction: %p", act);
			end else begin
				e = pending_rsp.pop_front();
				if (act !== e) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"mismatch: x %0d/%0d y %0d/%0d ang %0d/%0d ok %0b/%0b ",
							"st %0d/%0d cnt %0d/%0d len %h/%h (exp/act)"},
							e.x, act.x, e.y, act.y, e.ang, act.ang, e.ok, act.ok,
							e.st, act.st, e.cnt, act.cnt, e.len, act.len);
				end
			end
			rx_stall = draw_gap();
		end
		rsp_if.ready <= !hold && rx_stall == 0;
		if (rx_stall > 0)
			rx_stall--;
	end

	initial begin
		req_t r;
		rsp_t none;
		hold      = 1'b0;
		no_idle   = 1'b0;
		req_up    = 1'b0;
		next_gap  = 1;
		walk_x    = 0;
		walk_y    = 0;
		min_len   = '0;
		none      = '0;
		clear_path();
		arst_n                  <= 1'b0;
		req_if.valid            <= 1'b0;
		req_if.opcode           <= OP_ADD;
		req_if.point_x          <= '0;
		req_if.point_y          <= '0;
		req_if.query_offset     <= '0;
		req_if.query_end_offset <= '0;
		req_if.max_angle_change <= '0;
		cfg_if.valid            <= 1'b0;
		cfg_if.data             <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// empty path, spare opcodes, dropped points, extremes, clearing
		add_row(OP_POINT, 0, 0, 0, 0, 16'd0, 1, fixed_rsp(0, ST_EMPTY, 0));
		add_row(OP_ANGLE, 0, 0, -1, 0, 16'd0, 1, fixed_rsp(0, ST_EMPTY, 0));
		add_row(OP_VAR, 0, 0, 0, 1000, 16'd0, 1, fixed_rsp(1, ST_EMPTY, 0));
		add_row(OP_SPARE_LO, -1, -1, -1, -1, 16'hFFFF, 1, fixed_rsp(0, ST_OK, 0));
		add_row(OP_SPARE_HI, 0, 0, 0, 0, 16'd0, 1, fixed_rsp(0, ST_OK, 0));
		add_row(OP_ADD, 0, 0, 0, 0, 16'd0, 1, fixed_rsp(0, ST_OK, 1));
		add_row(OP_ADD, 0, 0, 0, 0, 16'd0, 1, fixed_rsp(0, ST_OK, 1));
		add_row(OP_ADD, 2560, 0, 0, 0, 16'd0, 0, none);
		add_row(OP_ADD, 2560, -2560, 0, 0, 16'd0, 0, none);
		add_row(OP_ADD, -2560, -2560, 0, 0, 16'd0, 0, none);
		add_row(OP_POINT, 0, 0, -5, 0, 16'd0, 0, none);
		add_row(OP_POINT, 0, 0, 3000, 0, 16'd0, 0, none);
		add_row(OP_POINT, 0, 0, 32'sh7FFF_FFFF, 0, 16'd0, 0, none);
		add_row(OP_ANGLE, 0, 0, 0, 0, 16'd0, 0, none);
		add_row(OP_ANGLE, 0, 0, 6000, 0, 16'd0, 0, none);
		add_row(OP_VAR, 0, 0, 0, 32'sh7FFF_FFFF, 16'd0, 0, none);
		add_row(OP_VAR, 0, 0, 0, 32'sh7FFF_FFFF, 16'd32768, 0, none);
		add_row(OP_VAR, 0, 0, 5000, -5000, 16'd100, 0, none);
		add_row(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 16'd0, 0, none);
		add_row(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 16'd0, 0, none);
		add_row(OP_POINT, 0, 0, 32'sh7FFF_FFFF, 0, 16'd0, 0, none);
		add_row(OP_ANGLE, 0, 0, 32'sh8000_0000, 0, 16'd0, 0, none);
		add_row(OP_CLEAR, 0, 0, 0, 0, 16'd0, 1, fixed_rsp(0, ST_OK, 0));
		add_row(OP_POINT, 0, 0, 0, 0, 16'd0, 1, fixed_rsp(0, ST_EMPTY, 0));

		write_min_len(32'd0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].e);

		// every point after the first of a path is within the minimum length
		write_min_len(32'hFFFF_FFFF);
		for (int i = 0; i < 30; i++)
			send_item(random_item(0, 3000), 0, none);

		write_min_len(32'd1000);
		for (int i = 0; i < 200; i++) begin
			if (i == 100)
				fork
					begin
						hold = 1'b1;
						repeat (400) @(posedge clk);
						hold = 1'b0;
					end
				join_none
			if (i == 150)
				drain();
			send_item(random_item(0, 6000), 0, none);
		end

		write_min_len(32'd128);
		for (int i = 0; i < 180; i++) begin
			no_idle = (i >= 40 && i < 100);
			send_item(random_item(0, 20000), 0, none);
		end
		no_idle = 1'b0;

		// fill the segment table and the index
		write_min_len(32'd0);
		r = '{OP_CLEAR, 0, 0, 0, 0, 16'd0};
		send_item(r, 0, none);
		for (int i = 0; i < 1030; i++)
			send_item(random_item(1, 40000), 0, none);

		drain();
		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
